[src/led_flash_sequencer_unit_macros.svh]
// Assertion macros for the LED flash sequencer.
`ifndef LED_FLASH_SEQUENCER_UNIT_MACROS_SVH
`define LED_FLASH_SEQUENCER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LFS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LFS_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[src/lfs_pkg.sv]
// Package with types and constants of the LED flash sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lfs_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int KIND_W        = 2;
  localparam int FIELD_W       = 16;
  localparam int COUNT_W       = 16;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   endless_mode;
    logic   led_level;
  } seq_ctl_t;

endpackage
`default_nettype wire

[src/led_flash_sequencer_unit.sv]
// Top level of the LED flash sequencer: input register, step logic, result register.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | kind, times, count, flags, level
//   out_    | output    | out_valid / out_ready | led_on, busy_res
//
// One word per cycle sustained while out_ready stays high; a result passes through the input
// register, then the state update into the result register, before it is presented.
// Synchronous active-low reset clears the sequence state and both valid flags.
// While out_ready is low the result holds; the input register takes one more word,
// then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module led_flash_sequencer_unit #(
  parameter int TIME_BITS = lfs_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lfs_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_on_time,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_start_delay,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_off_time,
  input  wire logic                        in_off_same,
  input  wire logic [lfs_pkg::COUNT_W-1:0] in_flash_count,
  input  wire logic                        in_endless,
  input  wire logic                        in_level,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_led_on,
  output logic                             out_busy_res
);
  import lfs_pkg::*;

  logic                 stg_valid_r;
  logic [KIND_W-1:0]    stg_kind_r;
  logic [FIELD_W-1:0]   stg_on_time_r;
  logic [FIELD_W-1:0]   stg_start_delay_r;
  logic [FIELD_W-1:0]   stg_off_time_r;
  logic                 stg_off_same_r;
  logic [COUNT_W-1:0]   stg_flash_count_r;
  logic                 stg_endless_r;
  logic                 stg_level_r;

  seq_ctl_t             ctl_r;
  seq_ctl_t             ctl_nxt;
  logic [TIME_BITS-1:0] timer_r;
  logic [TIME_BITS-1:0] timer_nxt;
  logic [COUNT_W-1:0]   flashes_r;
  logic [COUNT_W-1:0]   flashes_nxt;
  logic [TIME_BITS-1:0] on_r;
  logic [TIME_BITS-1:0] on_nxt;
  logic [TIME_BITS-1:0] off_r;
  logic [TIME_BITS-1:0] off_nxt;

  logic                 out_valid_r;
  logic                 out_led_on_r;
  logic                 out_busy_res_r;
  logic                 led_on_nxt;
  logic                 busy_res_nxt;
  logic                 advance;

  assign advance   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || advance;
  assign out_valid    = out_valid_r;
  assign out_led_on   = out_led_on_r;
  assign out_busy_res = out_busy_res_r;

  lfs_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .kind        (stg_kind_r),
    .on_time     (stg_on_time_r),
    .start_delay (stg_start_delay_r),
    .off_time    (stg_off_time_r),
    .off_same    (stg_off_same_r),
    .flash_count (stg_flash_count_r),
    .endless     (stg_endless_r),
    .level       (stg_level_r),
    .ctl         (ctl_r),
    .timer       (timer_r),
    .flashes     (flashes_r),
    .on_stored   (on_r),
    .off_stored  (off_r),
    .ctl_nxt     (ctl_nxt),
    .timer_nxt   (timer_nxt),
    .flashes_nxt (flashes_nxt),
    .on_nxt      (on_nxt),
    .off_nxt     (off_nxt),
    .led_on      (led_on_nxt),
    .busy_res    (busy_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '{phase: PH_IDLE, endless_mode: 1'b0, led_level: 1'b0};
      timer_r     <= '0;
      flashes_r   <= '0;
      on_r        <= '0;
      off_r       <= '0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        ctl_r       <= ctl_nxt;
        timer_r     <= timer_nxt;
        flashes_r   <= flashes_nxt;
        on_r        <= on_nxt;
        off_r       <= off_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load on accept, result registers on advance; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_kind_r        <= in_kind;
      stg_on_time_r     <= in_on_time;
      stg_start_delay_r <= in_start_delay;
      stg_off_time_r    <= in_off_time;
      stg_off_same_r    <= in_off_same;
      stg_flash_count_r <= in_flash_count;
      stg_endless_r     <= in_endless;
      stg_level_r       <= in_level;
    end
    if (advance) begin
      out_led_on_r   <= led_on_nxt;
      out_busy_res_r <= busy_res_nxt;
    end
  end

endmodule
`default_nettype wire

[src/lfs_step.sv]
// Next-state and result logic for one word of the LED flash sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lfs_step #(
  parameter int TIME_BITS = lfs_pkg::TIME_BITS_DEF
) (
  input  wire logic [lfs_pkg::KIND_W-1:0]  kind,
  input  wire logic [lfs_pkg::FIELD_W-1:0] on_time,
  input  wire logic [lfs_pkg::FIELD_W-1:0] start_delay,
  input  wire logic [lfs_pkg::FIELD_W-1:0] off_time,
  input  wire logic                        off_same,
  input  wire logic [lfs_pkg::COUNT_W-1:0] flash_count,
  input  wire logic                        endless,
  input  wire logic                        level,
  input  wire lfs_pkg::seq_ctl_t           ctl,
  input  wire logic [TIME_BITS-1:0]        timer,
  input  wire logic [lfs_pkg::COUNT_W-1:0] flashes,
  input  wire logic [TIME_BITS-1:0]        on_stored,
  input  wire logic [TIME_BITS-1:0]        off_stored,
  output lfs_pkg::seq_ctl_t                ctl_nxt,
  output logic [TIME_BITS-1:0]             timer_nxt,
  output logic [lfs_pkg::COUNT_W-1:0]      flashes_nxt,
  output logic [TIME_BITS-1:0]             on_nxt,
  output logic [TIME_BITS-1:0]             off_nxt,
  output logic                             led_on,
  output logic                             busy_res
);
  import lfs_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

  logic [TIME_BITS-1:0] start_on;
  logic [TIME_BITS-1:0] start_dly;
  logic [TIME_BITS-1:0] start_off;
  logic                 run_out;

  assign start_on  = TIME_BITS'(on_time);
  assign start_dly = TIME_BITS'(start_delay);
  assign start_off = TIME_BITS'(off_time);
  assign run_out   = !ctl.endless_mode && (flashes == '0);

  always_comb begin
    ctl_nxt     = ctl;
    timer_nxt   = timer;
    flashes_nxt = flashes;
    on_nxt      = on_stored;
    off_nxt     = off_stored;
    case (kind)
      KIND_TICK: begin
        if (ctl.phase != PH_IDLE) begin
          if (timer > TIME_ONE) begin
            timer_nxt = timer - TIME_ONE;
          end else begin
            timer_nxt = '0;
            case (ctl.phase)
              PH_ON: begin
                if (run_out) begin
                  ctl_nxt.phase     = PH_IDLE;
                  ctl_nxt.led_level = 1'b0;
                end else begin
                  ctl_nxt.phase     = PH_OFF;
                  timer_nxt         = off_stored;
                  ctl_nxt.led_level = 1'b0;
                end
              end
              PH_DELAY, PH_OFF: begin
                if (run_out) begin
                  ctl_nxt.phase     = PH_IDLE;
                  ctl_nxt.led_level = 1'b0;
                end else begin
                  if (!ctl.endless_mode) begin
                    flashes_nxt = flashes - COUNT_W'(1);
                  end
                  ctl_nxt.phase     = PH_ON;
                  timer_nxt         = on_stored;
                  ctl_nxt.led_level = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      KIND_START: begin
        on_nxt               = start_on;
        off_nxt              = off_same ? start_on : start_off;
        ctl_nxt.endless_mode = endless;
        flashes_nxt          = endless ? '0 : flash_count;
        ctl_nxt.led_level    = 1'b0;
        if (start_dly != '0) begin
          ctl_nxt.phase = PH_DELAY;
          timer_nxt     = start_dly;
        end else begin
          timer_nxt = '0;
          if (!endless && (flash_count == '0)) begin
            ctl_nxt.phase = PH_IDLE;
          end else begin
            if (!endless) begin
              flashes_nxt = flash_count - COUNT_W'(1);
            end
            ctl_nxt.phase     = PH_ON;
            timer_nxt         = start_on;
            ctl_nxt.led_level = 1'b1;
          end
        end
      end
      KIND_SET: begin
        ctl_nxt.phase     = PH_IDLE;
        timer_nxt         = '0;
        ctl_nxt.led_level = level;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    led_on   = ctl_nxt.led_level;
    busy_res = (ctl_nxt.phase != PH_IDLE);
  end

endmodule
`default_nettype wire

[src/lfs_checker.sv]
// Port-level assertions for the LED flash sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "led_flash_sequencer_unit_macros.svh"
module lfs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_led_on,
  input wire logic out_busy_res
);

  `LFS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_led_on) && $stable(out_busy_res)), "result word changed while stalled")
  `LFS_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty result register")
  `LFS_ASSERT(a_word_delivered, clk, rst_n, (in_valid && in_ready) |-> ##2 out_valid, "accepted word did not reach the result register")
  `LFS_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind led_flash_sequencer_unit lfs_checker u_lfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_led_on   (out_led_on),
  .out_busy_res (out_busy_res)
);
`default_nettype wire

[tb/sv/led_seq_checker.sv]
// Checker for the LED flash sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps
module led_seq_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [lfs_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_on_time,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_start_delay,
  input  wire logic [lfs_pkg::FIELD_W-1:0] in_off_time,
  input  wire logic                        in_off_same,
  input  wire logic [lfs_pkg::COUNT_W-1:0] in_flash_count,
  input  wire logic                        in_endless,
  input  wire logic                        in_level,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic                        out_led_on,
  input  wire logic                        out_busy_res,
  output int                               fail_count,
  output int                               outstanding
);
  import lfs_pkg::*;

  typedef struct packed {
    logic led;
    logic busy;
  } led_state_t;

  phase_t                   seq_phase;
  logic [TIME_BITS_DEF-1:0] ticks_left;
  logic [COUNT_W-1:0]       flashes_left;
  logic [TIME_BITS_DEF-1:0] lit_ticks;
  logic [TIME_BITS_DEF-1:0] dark_ticks;
  logic                     endless_q;
  logic                     led_q;
  led_state_t               expected_leds[$];

  task automatic end_sequence();
    seq_phase  = PH_IDLE;
    ticks_left = '0;
    led_q      = 1'b0;
  endtask

  task automatic begin_flash();
    if (!endless_q && flashes_left == '0) begin
      end_sequence();
    end else begin
      if (!endless_q) flashes_left = flashes_left - 1'b1;
      seq_phase  = PH_ON;
      ticks_left = lit_ticks;
      led_q      = 1'b1;
    end
  endtask

  task automatic advance_tick();
    if (seq_phase == PH_IDLE) return;
    if (ticks_left > 1) begin
      ticks_left = ticks_left - 1'b1;
      return;
    end
    ticks_left = '0;
    case (seq_phase)
      PH_DELAY: begin_flash();
      PH_ON: begin
        if (!endless_q && flashes_left == '0) begin
          end_sequence();
        end else begin
          seq_phase  = PH_OFF;
          ticks_left = dark_ticks;
          led_q      = 1'b0;
        end
      end
      default: begin_flash();
    endcase
  endtask

  task automatic apply_word();
    case (in_kind)
      KIND_TICK: advance_tick();
      KIND_START: begin
        lit_ticks    = in_on_time;
        dark_ticks   = in_off_same ? in_on_time : in_off_time;
        endless_q    = in_endless;
        flashes_left = in_endless ? '0 : in_flash_count;
        led_q        = 1'b0;
        if (in_start_delay != '0) begin
          seq_phase  = PH_DELAY;
          ticks_left = in_start_delay;
        end else begin
          ticks_left = '0;
          begin_flash();
        end
      end
      KIND_SET: begin
        seq_phase  = PH_IDLE;
        ticks_left = '0;
        led_q      = in_level;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    led_state_t exp_word;
    if (!rst_n) begin
      seq_phase    = PH_IDLE;
      ticks_left   = '0;
      flashes_left = '0;
      lit_ticks    = '0;
      dark_ticks   = '0;
      endless_q    = 1'b0;
      led_q        = 1'b0;
      fail_count   = 0;
      expected_leds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result word led_on=%0b busy_res=%0b",
                     $realtime, out_led_on, out_busy_res);
          fail_count++;
        end else begin
          exp_word = expected_leds.pop_front();
          if (out_led_on !== exp_word.led || out_busy_res !== exp_word.busy) begin
            if (fail_count < 10)
              $display("%0t: mismatch led_on exp %0b got %0b, busy_res exp %0b got %0b",
                       $realtime, exp_word.led, out_led_on, exp_word.busy, out_busy_res);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_word();
        exp_word.led  = led_q;
        exp_word.busy = (seq_phase != PH_IDLE);
        expected_leds.push_back(exp_word);
      end
    end
    outstanding = expected_leds.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the LED flash sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import lfs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind;
  logic [FIELD_W-1:0] in_on_time;
  logic [FIELD_W-1:0] in_start_delay;
  logic [FIELD_W-1:0] in_off_time;
  logic               in_off_same;
  logic [COUNT_W-1:0] in_flash_count;
  logic               in_endless;
  logic               in_level;
  logic               out_valid;
  logic               out_ready;
  logic               out_led_on;
  logic               out_busy_res;
  int                 fail_count;
  int                 outstanding;

  int words_sent   = 0;
  int snd_idle_pct = 38;
  int rcv_idle_pct = 62;
  bit hold_req     = 0;
  int hold_left    = 0;

  led_flash_sequencer_unit uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_on_time, .in_start_delay,
    .in_off_time, .in_off_same, .in_flash_count, .in_endless, .in_level,
    .out_valid, .out_ready, .out_led_on, .out_busy_res
  );

  led_seq_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_on_time, .in_start_delay,
    .in_off_time, .in_off_same, .in_flash_count, .in_endless, .in_level,
    .out_valid, .out_ready, .out_led_on, .out_busy_res, .fail_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [FIELD_W-1:0] on_t,
                           input logic [FIELD_W-1:0] dly, input logic [FIELD_W-1:0] off_t,
                           input logic same, input logic [COUNT_W-1:0] cnt,
                           input logic endl, input logic lvl);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_on_time     <= on_t;
    in_start_delay <= dly;
    in_off_time    <= off_t;
    in_off_same    <= same;
    in_flash_count <= cnt;
    in_endless     <= endl;
    in_level       <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_noise(input logic [KIND_W-1:0] k);
    send_word(k, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom),
              COUNT_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_noise(KIND_TICK);
  endtask

  task automatic send_start(input logic [FIELD_W-1:0] on_t, input logic [FIELD_W-1:0] dly,
                            input logic [FIELD_W-1:0] off_t, input logic same,
                            input logic [COUNT_W-1:0] cnt, input logic endl);
    send_word(KIND_START, on_t, dly, off_t, same, cnt, endl, 1'($urandom));
  endtask

  function automatic logic [FIELD_W-1:0] pick_time();
    return ($urandom_range(99) < 92) ? FIELD_W'($urandom_range(4)) : FIELD_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    return ($urandom_range(99) < 95) ? COUNT_W'($urandom_range(4)) : COUNT_W'($urandom);
  endfunction

  task automatic run_random(input int upto);
    int n;
    int r;
    while (words_sent < upto) begin
      if ($urandom_range(99) < 85) begin
        send_start(pick_time(), pick_time(), pick_time(), 1'($urandom), pick_count(),
                   $urandom_range(99) < 15);
        n = $urandom_range(40);
        repeat (n) begin
          r = $urandom_range(99);
          if (r < 2) send_noise(KIND_SET);
          else if (r < 3) send_noise(KIND_UNUSED);
          else send_noise(KIND_TICK);
        end
      end else begin
        send_noise(KIND_W'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_TICK;
    in_on_time     <= '0;
    in_start_delay <= '0;
    in_off_time    <= '0;
    in_off_same    <= 1'b0;
    in_flash_count <= '0;
    in_endless     <= 1'b0;
    in_level       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_ticks(1);
    send_word(KIND_SET, 0, 0, 0, 0, 0, 0, 1'b1);
    send_word(KIND_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 1, 1'b0);
    send_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 1, 1'b1);
    send_start(0, 0, 0, 0, 0, 0);
    send_start(0, 0, 5, 0, 1, 0);
    send_ticks(2);
    send_start(2, 1, 1, 0, 2, 0);
    send_ticks(6);
    send_start(1, 0, 7, 1, 0, 1);
    send_ticks(3);
    send_word(KIND_SET, 0, 0, 0, 0, 0, 0, 1'b1);
    send_start(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0);
    send_ticks(2);
    send_start(3, 1, 3, 0, 0, 0);
    send_ticks(1);

    hold_req = 1;
    run_random(420);
    snd_idle_pct = 62;
    rcv_idle_pct = 38;
    run_random(840);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1;
    run_random(1250);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
